// File: design/utf16_to_utf8_transcoder_unit_defines.svh
// Assertion macros for the UTF-16 to UTF-8 transcoder RTL, used by the serializer.
// Depends on nothing; each macro expects clk_i and rst_ni in scope.
`ifndef UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define U2U8_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define U2U8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/u2u8_pkg.sv
// Shared constants and types for the UTF-16 to UTF-8 transcoder.
// No dependencies; used by the decoder, the serializer and the top level.
package u2u8_pkg;

  // UTF-16 surrogate ranges.
  localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
  localparam logic [15:0] SURR_HIGH_LAST  = 16'hDBFF;
  localparam logic [15:0] SURR_LOW_FIRST  = 16'hDC00;
  localparam logic [15:0] SURR_LOW_LAST   = 16'hDFFF;

  // Upper limits of the one- and two-byte UTF-8 forms.
  localparam logic [15:0] ONE_BYTE_MAX = 16'h007F;
  localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;

  // Offset of the supplementary planes, in units of 1024 code points.
  localparam logic [10:0] PLANE_OFFSET = 11'd64;

  // UTF-8 lead and continuation byte markers.
  localparam logic [7:0] LEAD_TWO   = 8'hC0;
  localparam logic [7:0] LEAD_THREE = 8'hE0;
  localparam logic [7:0] LEAD_FOUR  = 8'hF0;
  localparam logic [7:0] CONT_MARK  = 8'h80;

  // Maximum number of results caused by one input beat.
  localparam int unsigned MAX_RESULTS = 4;

  // Results of one input beat, handed from the decoder to the serializer.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;     // bytes[0] goes out first
    logic [2:0]                  cnt;       // number of results, 0 means none
    logic                        has_bytes; // 0 for a status-only result
    logic                        done;      // beat closes the string
    logic                        status;    // 1 when the string is invalid
  } burst_t;

endpackage

// File: design/u2u8_decode.sv
// Code unit decoder: surrogate pairing, validity tracking and UTF-8 encoding.
// Depends on u2u8_pkg.
module u2u8_decode
  import u2u8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [15:0] code_unit_i,
  input  logic        has_unit_i,
  input  logic        string_end_i,
  input  logic        empty_ok_i,
  output burst_t      burst_o
);

  logic [9:0]  held_q, held_d;
  logic        pend_q, pend_d;
  logic        inv_q, inv_d;
  logic        emit_q, emit_d;
  logic [10:0] plane;
  logic [20:0] cp;
  logic [2:0]  n_enc;
  logic        bad;

  // Code point of a surrogate pair.
  assign plane = {1'b0, held_q} + PLANE_OFFSET;
  assign cp    = {plane, code_unit_i[9:0]};

  // Per-beat decode and next state.
  always_comb begin
    burst_o = '0;
    held_d  = held_q;
    pend_d  = pend_q;
    inv_d   = inv_q;
    emit_d  = emit_q;
    n_enc   = 3'd0;
    bad     = 1'b0;

    if (has_unit_i && !inv_q) begin
      if (pend_q) begin
        pend_d = 1'b0;
        held_d = '0;
        if (code_unit_i inside {[SURR_LOW_FIRST:SURR_LOW_LAST]}) begin
          burst_o.bytes[0] = LEAD_FOUR | {5'd0, cp[20:18]};
          burst_o.bytes[1] = CONT_MARK | {2'd0, cp[17:12]};
          burst_o.bytes[2] = CONT_MARK | {2'd0, cp[11:6]};
          burst_o.bytes[3] = CONT_MARK | {2'd0, cp[5:0]};
          n_enc            = 3'd4;
        end else begin
          inv_d = 1'b1;
        end
      end else if (code_unit_i == '0) begin
        inv_d = 1'b1;
      end else if (code_unit_i inside {[SURR_HIGH_FIRST:SURR_HIGH_LAST]}) begin
        held_d = code_unit_i[9:0];
        pend_d = 1'b1;
      end else if (code_unit_i inside {[SURR_LOW_FIRST:SURR_LOW_LAST]}) begin
        inv_d = 1'b1;
      end else if (code_unit_i <= ONE_BYTE_MAX) begin
        burst_o.bytes[0] = code_unit_i[7:0];
        n_enc            = 3'd1;
      end else if (code_unit_i <= TWO_BYTE_MAX) begin
        burst_o.bytes[0] = LEAD_TWO | {3'd0, code_unit_i[10:6]};
        burst_o.bytes[1] = CONT_MARK | {2'd0, code_unit_i[5:0]};
        n_enc            = 3'd2;
      end else begin
        burst_o.bytes[0] = LEAD_THREE | {4'd0, code_unit_i[15:12]};
        burst_o.bytes[1] = CONT_MARK | {2'd0, code_unit_i[11:6]};
        burst_o.bytes[2] = CONT_MARK | {2'd0, code_unit_i[5:0]};
        n_enc            = 3'd3;
      end
    end

    if (n_enc != 3'd0) begin
      emit_d = 1'b1;
    end

    burst_o.has_bytes = (n_enc != 3'd0);
    burst_o.cnt       = n_enc;

    // The closing beat reports status and returns the string state to idle.
    if (string_end_i) begin
      bad            = inv_d || pend_d || (!empty_ok_i && !emit_d);
      burst_o.done   = 1'b1;
      burst_o.status = bad;
      if (n_enc == 3'd0) begin
        burst_o.cnt = 3'd1;
      end
      held_d = '0;
      pend_d = 1'b0;
      inv_d  = 1'b0;
      emit_d = 1'b0;
    end
  end

  // String state advances only on an accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pend_q <= 1'b0;
      inv_q  <= 1'b0;
      emit_q <= 1'b0;
    end else if (accept_i) begin
      held_q <= held_d;
      pend_q <= pend_d;
      inv_q  <= inv_d;
      emit_q <= emit_d;
    end
  end

endmodule

// File: design/u2u8_serializer.sv
// Burst and output registers: send a beat's results one per cycle unless
// out_ready_i stalls. Depends on u2u8_pkg and the assertion macro header.
`include "utf16_to_utf8_transcoder_unit_defines.svh"

module u2u8_serializer
  import u2u8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  burst_t     burst_i,
  output logic       ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       string_done_o,
  output logic       status_o
);

  burst_t     burst_q;
  logic       bvalid_q, bvalid_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       pop;
  logic       pop_last;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_bv_q;
  logic       out_last_q;
  logic       out_done_q;
  logic       out_status_q;

  // A result moves into the output register whenever that register frees up.
  assign pop      = bvalid_q && (!out_valid_q || out_ready_i);
  assign pop_last = pop && (cnt_q == 3'd1);
  assign ready_o  = !bvalid_q || pop_last;

  // Burst register control.
  always_comb begin
    bvalid_d = bvalid_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    if (load_i) begin
      bvalid_d = 1'b1;
      cnt_d    = burst_i.cnt;
      idx_d    = '0;
    end else if (pop) begin
      bvalid_d = !pop_last;
      cnt_d    = cnt_q - 3'd1;
      idx_d    = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
      cnt_q    <= '0;
      idx_q    <= '0;
    end else begin
      bvalid_q <= bvalid_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      burst_q <= burst_i;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_byte_q   <= burst_q.has_bytes ? burst_q.bytes[idx_q] : 8'd0;
      out_bv_q     <= burst_q.has_bytes;
      out_last_q   <= (cnt_q == 3'd1);
      out_done_q   <= (cnt_q == 3'd1) && burst_q.done;
      out_status_q <= (cnt_q == 3'd1) && burst_q.status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_valid_o  = out_bv_q;
  assign run_last_o    = out_last_q;
  assign string_done_o = out_done_q;
  assign status_o      = out_status_q;

  // A held burst always has between one and four results left.
  `U2U8_ASSERT_IMPLIES(a_cnt_range, bvalid_q, (cnt_q != 3'd0) && (cnt_q <= 3'd4), "burst count out of range")
  // A new burst may only replace one whose final result leaves this cycle.
  `U2U8_ASSERT_IMPLIES(a_no_overwrite, load_i && bvalid_q, pop_last, "burst overwritten")
  // Status and string end only ride on the last result of a beat.
  `U2U8_ASSERT_IMPLIES(a_done_last, out_valid_q && out_done_q, out_last_q, "string end not on last result")
  `U2U8_ASSERT_IMPLIES(a_status_done, out_valid_q && out_status_q, out_done_q, "status outside string end")
  // A result without a byte is only the status result of a closing beat.
  `U2U8_ASSERT_IMPLIES(a_bare_status, out_valid_q && !out_bv_q, out_done_q, "empty result not closing")
  // After a final result is taken, the output is empty unless another was queued.
  `U2U8_ASSERT_NEXT(a_drain, out_valid_q && out_ready_i && !bvalid_q, !out_valid_q, "stale result")

endmodule

// File: design/utf16_to_utf8_transcoder_unit.sv
// UTF-16 to UTF-8 transcoder, top level. A beat is decoded into the burst
// register when it is accepted, and its results then pass one at a time into
// the output register. Rate: one result per cycle while the output stream
// accepts; a new beat is taken as the last result of the previous one leaves.
// Reset (rst_ni low, asynchronous) clears the string state, the empty-string
// setting and all valid flags. Depends on u2u8_pkg, u2u8_decode, u2u8_serializer.
module utf16_to_utf8_transcoder_unit
  import u2u8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: empty_ok, 1 accepts a string that produced no bytes.
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] code_unit
  input  logic        s_axis_tuser_i,   // [0] has_unit
  input  logic        s_axis_tlast_i,   // string_end
  // Output stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser_o,   // [0] byte_valid, [1] run_last, [2] status
  output logic        m_axis_tlast_o    // string_done
);

  logic   empty_ok_q;
  logic   accept;
  logic   ready;
  burst_t burst;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      empty_ok_q <= 1'b0;
    end else if (cfg_we_i) begin
      empty_ok_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready_o = ready;
  assign accept          = s_axis_tvalid_i && ready;

  u2u8_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .code_unit_i   (s_axis_tdata_i),
    .has_unit_i    (s_axis_tuser_i),
    .string_end_i  (s_axis_tlast_i),
    .empty_ok_i    (empty_ok_q),
    .burst_o       (burst)
  );

  u2u8_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept && (burst.cnt != 3'd0)),
    .burst_i       (burst),
    .ready_o       (ready),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_byte_o    (m_axis_tdata_o),
    .byte_valid_o  (m_axis_tuser_o[0]),
    .run_last_o    (m_axis_tuser_o[1]),
    .string_done_o (m_axis_tlast_o),
    .status_o      (m_axis_tuser_o[2])
  );

endmodule
